### rtl/depth_pixel_backprojection_defines.svh
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_defines
// assertion macros shared by dpb_queue and dpb_back
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// same-cycle implication under synchronous reset
`define DPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpb check failed");

// next-cycle implication under synchronous reset
`define DPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpb check failed");

`endif

### rtl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// types and constants of the depth pixel back-projection block
// ----------------------------------------------------------------------------
package dpb_pkg;

  typedef enum logic [2:0] {
    REG_INV_FX  = 3'd0,
    REG_INV_FY  = 3'd1,
    REG_PP      = 3'd2,
    REG_POSE_X  = 3'd3,
    REG_POSE_Y  = 3'd4,
    REG_POSE_Z  = 3'd5,
    REG_MODE    = 3'd6
  } dpb_reg_t;

  typedef enum logic [1:0] {
    CM_RGB  = 2'd0,
    CM_RGBA = 2'd1,
    CM_GRAY = 2'd2,
    CM_ALT  = 2'd3
  } dpb_cmode_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [31:0]      inv_fx;
    logic [31:0]      inv_fy;
    logic [31:0]      pp;
    logic [2:0][63:0] pose;
    logic [4:0]       mode;
  } dpb_cfg_t;

  typedef struct packed {
    logic [1:0][15:0] aoff;
    logic [1:0]       neg;
    logic [23:0]      depth;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             pvalid;
  } dpb_item_t;

endpackage

### rtl/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front
// accepts pixels, drops off-grid and (without the keep bit) zero-depth ones, picks colours, forms pixel offsets
// ----------------------------------------------------------------------------
module dpb_front #(
  parameter int COORD_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dpb_pkg::dpb_cfg_t cfg,
  input  logic              in_push,
  output logic              in_full,
  input  logic [23:0]       in_depth,
  input  logic [11:0]       in_column,
  input  logic [11:0]       in_row,
  input  logic [7:0]        in_color_ch0,
  input  logic [7:0]        in_color_ch1,
  input  logic [7:0]        in_color_ch2,
  input  logic [7:0]        in_color_ch3,
  output logic              q_push,
  input  logic              q_full,
  output dpb_pkg::dpb_item_t q_item
);
  import dpb_pkg::*;

  localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

  logic       f_v_r, f_v_nxt;
  dpb_item_t  f_item_r, f_item_nxt;
  logic       f_en, acc, on_grid, keep;
  logic [11:0] col, row;
  logic [2:0]  smask;
  logic signed [16:0] off [2];

  assign f_en    = !f_v_r || !q_full;
  assign in_full = !f_en;
  assign acc     = in_push && f_en;
  assign col     = in_column & CMASK;
  assign row     = in_row & CMASK;
  assign smask   = 3'((4'd1 << cfg.mode[1:0]) - 4'd1);
  assign on_grid = ((col[2:0] & smask) == 3'd0) && ((row[2:0] & smask) == 3'd0);
  assign keep    = on_grid && ((in_depth != 24'd0) || cfg.mode[2]);

  always_comb begin
    off[0] = $signed({1'b0, col, 4'd0}) - $signed({1'b0, cfg.pp[15:0]});
    off[1] = $signed({1'b0, row, 4'd0}) - $signed({1'b0, cfg.pp[31:16]});
    f_item_nxt = '0;
    for (int a = 0; a < 2; a++) begin
      f_item_nxt.neg[a]  = off[a][16];
      f_item_nxt.aoff[a] = off[a][16] ? 16'(-off[a]) : off[a][15:0];
    end
    f_item_nxt.depth  = in_depth;
    f_item_nxt.pvalid = (in_depth != 24'd0);
    f_item_nxt.red    = in_color_ch0;
    unique case (dpb_cmode_t'(cfg.mode[4:3]))
      CM_RGB: begin
        f_item_nxt.green = in_color_ch1;
        f_item_nxt.blue  = in_color_ch2;
      end
      CM_RGBA: begin
        f_item_nxt.green = in_color_ch1;
        f_item_nxt.blue  = in_color_ch3;
      end
      default: begin
        f_item_nxt.green = in_color_ch0;
        f_item_nxt.blue  = in_color_ch0;
      end
    endcase
    if (in_depth == 24'd0) begin
      f_item_nxt.red   = '0;
      f_item_nxt.green = '0;
      f_item_nxt.blue  = '0;
    end
  end

  assign f_v_nxt = f_en ? (acc && keep) : f_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign q_push = f_v_r && !q_full;
  assign q_item = f_item_r;

endmodule

### rtl/dpb_queue.sv
// ----------------------------------------------------------------------------
// dpb_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_defines.svh"

module dpb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dpb_pkg::dpb_item_t push_item,
  output logic               full,
  input  logic               pop,
  output dpb_pkg::dpb_item_t pop_item,
  output logic               empty
);
  import dpb_pkg::*;

  dpb_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rp_r];
  assign wp_nxt   = do_push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt   = do_pop ? rp_r + 1'b1 : rp_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  `DPB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (QPTR_W+1)'(QDEPTH))
  `DPB_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty)
  `DPB_ASSERT_NOW(a_ptr_gap, 1'b1, (cnt_r == '0) || (cnt_r == (QPTR_W+1)'(QDEPTH)) || (QPTR_W'(wp_r - rp_r) == cnt_r[QPTR_W-1:0]))

endmodule

### rtl/dpb_back.sv
// ----------------------------------------------------------------------------
// dpb_back
// five stage projection and pose pipeline, last stage is the result register
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_defines.svh"

module dpb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dpb_pkg::dpb_cfg_t  cfg,
  input  logic               q_empty,
  input  dpb_pkg::dpb_item_t q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_point_valid
);
  import dpb_pkg::*;

  localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
  localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

  logic        en;
  logic [5:1]  v_r, v_nxt;
  dpb_item_t   it_r [5:1];

  logic [39:0]        m1_r [2];
  logic [55:0]        ph2_r [2], pl2_r [2];
  logic signed [36:0] c3_r [2];
  logic signed [52:0] p4_r [3][3];
  logic signed [31:0] pt5_r [3], pt5_nxt [3];

  logic [56:0]        rsum [2];
  logic signed [55:0] acc [3];
  logic signed [41:0] sh [3];

  assign en    = !v_r[5] || out_pop;
  assign q_pop = en && !q_empty;

  always_comb begin
    v_nxt = v_r;
    if (en) begin
      v_nxt = {v_r[4:1], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rsum[a] = {1'b0, ph2_r[a]} + 57'd524288 + 57'(pl2_r[a][55:16]);
    end
    for (int r = 0; r < 3; r++) begin
      acc[r] = 56'(p4_r[r][0]) + 56'(p4_r[r][1]) + 56'(p4_r[r][2])
             + (56'($signed(cfg.pose[r][63:48])) <<< 22) + 56'sd8192;
      sh[r]  = acc[r][55:14];
      if (!it_r[4].pvalid) begin
        pt5_nxt[r] = '0;
      end else if (sh[r] > SAT_MAX) begin
        pt5_nxt[r] = 32'sh7fffffff;
      end else if (sh[r] < SAT_MIN) begin
        pt5_nxt[r] = 32'sh80000000;
      end else begin
        pt5_nxt[r] = sh[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[1] <= q_item;
      for (int s = 2; s <= 5; s++) begin
        it_r[s] <= it_r[s-1];
      end
      m1_r[0]  <= 40'(q_item.aoff[0]) * 40'(q_item.depth);
      m1_r[1]  <= 40'(q_item.aoff[1]) * 40'(q_item.depth);
      ph2_r[0] <= 56'(m1_r[0]) * 56'(cfg.inv_fx[31:16]);
      pl2_r[0] <= 56'(m1_r[0]) * 56'(cfg.inv_fx[15:0]);
      ph2_r[1] <= 56'(m1_r[1]) * 56'(cfg.inv_fy[31:16]);
      pl2_r[1] <= 56'(m1_r[1]) * 56'(cfg.inv_fy[15:0]);
      for (int a = 0; a < 2; a++) begin
        c3_r[a] <= it_r[2].neg[a] ? -$signed(rsum[a][56:20]) : $signed(rsum[a][56:20]);
      end
      for (int r = 0; r < 3; r++) begin
        p4_r[r][0] <= $signed(cfg.pose[r][15:0]) * c3_r[0];
        p4_r[r][1] <= $signed(cfg.pose[r][31:16]) * c3_r[1];
        p4_r[r][2] <= $signed(cfg.pose[r][47:32]) * $signed({13'd0, it_r[3].depth});
        pt5_r[r]   <= pt5_nxt[r];
      end
    end
  end

  assign out_empty       = !v_r[5];
  assign out_point_x     = pt5_r[0];
  assign out_point_y     = pt5_r[1];
  assign out_point_z     = pt5_r[2];
  assign out_red         = it_r[5].red;
  assign out_green       = it_r[5].green;
  assign out_blue        = it_r[5].blue;
  assign out_point_valid = it_r[5].pvalid;

  `DPB_ASSERT_NOW(a_hold_pop, v_r[5] && !out_pop, !q_pop)
  `DPB_ASSERT_NOW(a_placeholder, v_r[5] && !it_r[5].pvalid, (pt5_r[0] == '0) && (pt5_r[1] == '0) && (pt5_r[2] == '0) && (it_r[5].red == '0))
  `DPB_ASSERT_NEXT(a_advance, en && v_r[4], v_r[5])

endmodule

### rtl/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// depth pixel to posed point with colour, pinhole back-projection
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  in        in_push/in_full   depth, column, row, color_ch0..3
//  out       out_pop/out_empty point_x/y/z, red, green, blue, point_valid
//  cfg       cfg_we            cfg_index, cfg_data
//
// one pixel per cycle sustained while out_pop takes each result; a pixel passes the front
// register, the queue write and five back stages set by the projection multipliers
// a four-entry queue parts front and back, so each stalls on its own
// off-grid pixels, and zero depths without the keep bit, give no result
// synchronous active-low reset clears control state and config, not the data registers
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [23:0]        in_depth,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic [7:0]         in_color_ch0,
  input  logic [7:0]         in_color_ch1,
  input  logic [7:0]         in_color_ch2,
  input  logic [7:0]         in_color_ch3,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_point_valid
);
  import dpb_pkg::*;

  dpb_cfg_t  cfg_r, cfg_nxt;
  dpb_item_t f_item, q_item;
  logic      f_push, q_full, q_pop, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dpb_reg_t'(cfg_index))
        REG_INV_FX: cfg_nxt.inv_fx  = cfg_data[31:0];
        REG_INV_FY: cfg_nxt.inv_fy  = cfg_data[31:0];
        REG_PP:     cfg_nxt.pp      = cfg_data[31:0];
        REG_POSE_X: cfg_nxt.pose[0] = cfg_data;
        REG_POSE_Y: cfg_nxt.pose[1] = cfg_data;
        REG_POSE_Z: cfg_nxt.pose[2] = cfg_data;
        REG_MODE:   cfg_nxt.mode    = cfg_data[4:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_push, .in_full, .in_depth, .in_column, .in_row,
    .in_color_ch0, .in_color_ch1, .in_color_ch2, .in_color_ch3,
    .q_push(f_push), .q_full, .q_item(f_item)
  );

  dpb_queue u_queue (
    .clk, .rst_n,
    .push(f_push), .push_item(f_item), .full(q_full),
    .pop(q_pop), .pop_item(q_item), .empty(q_empty)
  );

  dpb_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_empty, .q_item, .q_pop,
    .out_empty, .out_pop, .out_point_x, .out_point_y, .out_point_z,
    .out_red, .out_green, .out_blue, .out_point_valid
  );

endmodule
